@@ rtl/core/rc3w_pkg.sv @@
// Shared types and constants for the 3x3 weighted RGBA convolution.
package rc3w_pkg;

  localparam int MaxWidthDef = 2048;
  localparam int PixW        = 8;
  localparam int RgbaW       = 4 * PixW;
  localparam int AccW        = 20;
  localparam int DivBits     = AccW;
  localparam int StepW       = 5;
  localparam int LwW         = 12;
  localparam logic [LwW-1:0] LwReset = 12'd640;

  typedef enum logic [2:0] {
    LN_HOLD,
    LN_MAC_FIRST,
    LN_MAC,
    LN_DIV_LOAD,
    LN_DIV_STEP
  } lane_op_t;

  typedef struct packed {
    lane_op_t op;
    logic     sat_clear;
  } lane_ctrl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_MAC,
    ST_DIV,
    ST_DONE
  } conv_state_t;

  typedef enum logic [1:0] {
    CFG_KERNEL_LO = 2'd0,
    CFG_KERNEL_HI = 2'd1,
    CFG_WEIGHT    = 2'd2,
    CFG_LINE_W    = 2'd3
  } cfg_idx_t;

endpackage

@@ rtl/core/rc3w_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module rc3w_ram #(
  parameter int Width = 32,
  parameter int Depth = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/core/rc3w_lane.sv @@
// One color lane: row-wise multiply-accumulate, then restoring division.
module rc3w_lane (
  input  logic                              clk,
  input  rc3w_pkg::lane_ctrl_t              ctrl,
  input  logic [2:0][rc3w_pkg::PixW-1:0]    pix,
  input  logic [2:0][rc3w_pkg::PixW-1:0]    coef,
  input  logic [rc3w_pkg::PixW-1:0]         weight,
  output logic [rc3w_pkg::PixW-1:0]         result
);
  import rc3w_pkg::*;

  logic [AccW-1:0]   acc_r, acc_nxt;
  logic [AccW-1:0]   quo_r, quo_nxt;
  logic [PixW:0]     rem_r, rem_nxt;
  logic [AccW-1:0]   row_sum;
  logic [PixW:0]     rem_sh;
  logic              fits;

  always_comb begin
    row_sum = AccW'(coef[0] * pix[0]) + AccW'(coef[1] * pix[1])
            + AccW'(coef[2] * pix[2]);
    rem_sh  = {rem_r[PixW-1:0], quo_r[AccW-1]};
    fits    = rem_sh >= {1'b0, weight};
    acc_nxt = acc_r;
    quo_nxt = quo_r;
    rem_nxt = rem_r;
    case (ctrl.op)
      LN_MAC_FIRST: acc_nxt = row_sum;
      LN_MAC:       acc_nxt = acc_r + row_sum;
      LN_DIV_LOAD: begin
        quo_nxt = acc_r;
        rem_nxt = '0;
      end
      LN_DIV_STEP: begin
        rem_nxt = fits ? rem_sh - {1'b0, weight} : rem_sh;
        quo_nxt = {quo_r[AccW-2:0], fits};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
  end

  // Saturate at full scale; a zero weight yields all ones and lands here too.
  assign result = (|quo_r[AccW-1:PixW] && !ctrl.sat_clear) ? '1 : quo_r[PixW-1:0];

endmodule

@@ rtl/core/rgba_conv3x3_weighted.sv @@
// Top level of the 3x3 weighted RGBA convolution with line stores.
//
// Usage: pixels enter in raster order on the in_ channel (valid/stall); an
// input request is taken when in_valid is high and in_stall low. in_frame_start
// marks the first pixel of an image. Each accepted pixel is written into the
// middle line store, whose old entry moves to the upper store, and shifts a
// 3x3 window. Once two rows and three columns of the current row are present,
// one filtered pixel leaves on the out_ channel for the window's top-left
// position; alpha passes through, row_end flags the last result of a row.
// Configure kernel, weight and line width through cfg_ only while idle.
// Sequence: one pixel at a time. A pixel with no result goes through a line
// store read, then a window update. A pixel with a result adds three MAC rows
// in each color lane, then a 20-bit restoring divide at one quotient bit per
// cycle, then the hand-off into the output register.
// Reset clears control state and loads register defaults (weight 1, line
// width 640); line stores are not cleared. A stalled result stays in the
// output register, and the next pixel is still taken and worked on; it waits
// at the end of its divide until the output register frees.
module rgba_conv3x3_weighted #(
  parameter int MAX_WIDTH = rc3w_pkg::MaxWidthDef
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [1:0]                   cfg_index,
  input  logic [47:0]                  cfg_data,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [rc3w_pkg::PixW-1:0]    in_red_in,
  input  logic [rc3w_pkg::PixW-1:0]    in_green_in,
  input  logic [rc3w_pkg::PixW-1:0]    in_blue_in,
  input  logic [rc3w_pkg::PixW-1:0]    in_alpha_in,
  input  logic                         in_frame_start,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [rc3w_pkg::PixW-1:0]    out_red_out,
  output logic [rc3w_pkg::PixW-1:0]    out_green_out,
  output logic [rc3w_pkg::PixW-1:0]    out_blue_out,
  output logic [rc3w_pkg::PixW-1:0]    out_alpha_out,
  output logic                         out_row_end
);
  import rc3w_pkg::*;

  localparam int AW  = $clog2(MAX_WIDTH);
  localparam int WW  = $clog2(MAX_WIDTH + 1);
  localparam int EW  = (WW > LwW) ? WW : LwW;
  localparam logic [EW-1:0] MaxW = EW'(MAX_WIDTH);
  localparam logic [EW-1:0] MinW = EW'(3);

  // Configuration registers
  logic [47:0]     kern_lo_r;
  logic [23:0]     kern_hi_r;
  logic [PixW-1:0] weight_r;
  logic [LwW-1:0]  line_w_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kern_lo_r <= '0;
      kern_hi_r <= '0;
      weight_r  <= PixW'(1);
      line_w_r  <= LwReset;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_KERNEL_LO: kern_lo_r <= cfg_data;
        CFG_KERNEL_HI: kern_hi_r <= cfg_data[23:0];
        CFG_WEIGHT:    weight_r  <= cfg_data[PixW-1:0];
        CFG_LINE_W:    line_w_r  <= cfg_data[LwW-1:0];
        default: ;
      endcase
    end
  end

  // Effective width: clamp line width to 3..MAX_WIDTH
  logic [EW-1:0] lw_ext, eff_w;
  always_comb begin
    lw_ext = EW'(line_w_r);
    if (lw_ext < MinW)      eff_w = MinW;
    else if (lw_ext > MaxW) eff_w = MaxW;
    else                    eff_w = lw_ext;
  end

  // Control state
  conv_state_t     state_r, state_nxt;
  logic [StepW-1:0] step_r, step_nxt;
  logic [AW-1:0]   col_cnt_r, col_cnt_nxt;
  logic [1:0]      rows_r, rows_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            accept, load_out;
  lane_ctrl_t      lane_ctrl;

  // Per-request payload
  logic [AW-1:0]   col_r;
  logic [RgbaW-1:0] pix_r;
  logic            emit_r, last_r;
  logic [2:0][2:0][RgbaW-1:0] win_r;

  // Column and row bookkeeping for an arriving pixel
  logic [AW-1:0]   col_base, col_now;
  logic [1:0]      rows_base, rows_now, rows_inc;
  logic            wrap, emit_now, last_now;

  always_comb begin
    col_base  = in_frame_start ? '0 : col_cnt_r;
    rows_base = in_frame_start ? '0 : rows_r;
    wrap      = EW'(col_base) >= eff_w;
    col_now   = wrap ? '0 : col_base;
    rows_now  = (wrap && rows_base != 2'd2) ? rows_base + 2'd1 : rows_base;
    rows_inc  = (rows_now != 2'd2) ? rows_now + 2'd1 : rows_now;
    emit_now  = (rows_now == 2'd2) && (col_now >= AW'(2));
    last_now  = (EW'(col_now) + EW'(1)) >= eff_w;
  end

  assign accept = in_valid && !in_stall;

  // Line stores
  logic [RgbaW-1:0] top_rd, mid_rd;
  logic             line_we;

  rc3w_ram #(.Width(RgbaW), .Depth(MAX_WIDTH)) u_upper (
    .clk   (clk),
    .we    (line_we),
    .waddr (col_r),
    .wdata (mid_rd),
    .raddr (col_now),
    .rdata (top_rd)
  );

  rc3w_ram #(.Width(RgbaW), .Depth(MAX_WIDTH)) u_middle (
    .clk   (clk),
    .we    (line_we),
    .waddr (col_r),
    .wdata (pix_r),
    .raddr (col_now),
    .rdata (mid_rd)
  );

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    col_cnt_nxt   = col_cnt_r;
    rows_nxt      = rows_r;
    load_out      = 1'b0;
    line_we       = 1'b0;
    lane_ctrl.op  = LN_HOLD;
    lane_ctrl.sat_clear = 1'b0;
    in_stall      = (state_r != ST_IDLE);
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt   = ST_READ;
          col_cnt_nxt = last_now ? '0 : col_now + AW'(1);
          rows_nxt    = last_now ? rows_inc : rows_now;
        end
      end
      ST_READ: begin
        // Store data is valid now: update both lines and the window
        line_we   = 1'b1;
        step_nxt  = '0;
        state_nxt = emit_r ? ST_MAC : ST_IDLE;
      end
      ST_MAC: begin
        lane_ctrl.op = (step_r == '0) ? LN_MAC_FIRST : LN_MAC;
        if (step_r == StepW'(2)) begin
          step_nxt  = '0;
          state_nxt = ST_DIV;
        end else begin
          step_nxt = step_r + StepW'(1);
        end
      end
      ST_DIV: begin
        lane_ctrl.op = (step_r == '0) ? LN_DIV_LOAD : LN_DIV_STEP;
        if (step_r == StepW'(DivBits)) begin
          state_nxt = ST_DONE;
        end else begin
          step_nxt = step_r + StepW'(1);
        end
      end
      ST_DONE: begin
        // Hold until the output register is free
        if (!out_valid_r || !out_stall) begin
          load_out  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
    out_valid_nxt = load_out || (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      col_cnt_r   <= '0;
      rows_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      col_cnt_r   <= col_cnt_nxt;
      rows_r      <= rows_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Capture the request and advance the window
  always_ff @(posedge clk) begin
    if (accept) begin
      col_r  <= col_now;
      pix_r  <= {in_alpha_in, in_blue_in, in_green_in, in_red_in};
      emit_r <= emit_now;
      last_r <= last_now;
    end
    if (state_r == ST_READ) begin
      for (int j = 0; j < 3; j++) begin
        win_r[j][0] <= win_r[j][1];
        win_r[j][1] <= win_r[j][2];
      end
      win_r[0][2] <= top_rd;
      win_r[1][2] <= mid_rd;
      win_r[2][2] <= pix_r;
    end
  end

  // Kernel row and window row for the current MAC step
  logic [8:0][PixW-1:0] kern;
  logic [2:0][PixW-1:0] coef_row;
  logic [2:0][RgbaW-1:0] win_row;

  assign kern = {kern_hi_r, kern_lo_r};

  always_comb begin
    case (step_r[1:0])
      2'd0: begin
        coef_row = kern[2:0];
        win_row  = win_r[0];
      end
      2'd1: begin
        coef_row = kern[5:3];
        win_row  = win_r[1];
      end
      default: begin
        coef_row = kern[8:6];
        win_row  = win_r[2];
      end
    endcase
  end

  // Color lanes, one per color channel (red, green, blue)
  logic [2:0][PixW-1:0] lane_res;

  for (genvar c = 0; c < 3; c++) begin : g_lane
    logic [2:0][PixW-1:0] lane_pix;
    always_comb begin
      for (int i = 0; i < 3; i++) begin
        lane_pix[i] = win_row[i][c*PixW +: PixW];
      end
    end
    rc3w_lane u_lane (
      .clk    (clk),
      .ctrl   (lane_ctrl),
      .pix    (lane_pix),
      .coef   (coef_row),
      .weight (weight_r),
      .result (lane_res[c])
    );
  end

  // Merge lane results into the output register
  always_ff @(posedge clk) begin
    if (load_out) begin
      out_red_out   <= lane_res[0];
      out_green_out <= lane_res[1];
      out_blue_out  <= lane_res[2];
      out_alpha_out <= win_r[0][0][RgbaW-1 -: PixW];
      out_row_end   <= last_r;
    end
  end

  assign out_valid = out_valid_r;

  // Checks
  a_accept_read: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r == ST_READ)
    else $error("accepted request did not go to line read");

  a_load_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_DONE))
    else $error("result appeared without finished divide");

  a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
    step_r <= StepW'(DivBits))
    else $error("step counter overran");

  a_rows_sat: assert property (@(posedge clk) disable iff (!rst_n)
    rows_r <= 2'd2)
    else $error("row count beyond saturation");

  a_mac_needs_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_READ && !emit_r) |=> state_r == ST_IDLE)
    else $error("filter started for a pixel without result");

endmodule
